@@ rtl/core/utf8_bmp_decoder_defines.svh @@
// Assertion macros for the UTF-8 BMP decoder.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef UTF8_BMP_DECODER_DEFINES_SVH
`define UTF8_BMP_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define U8BMP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("u8bmp assertion failed");
// Antecedent implies consequent in the following cycle.
`define U8BMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("u8bmp assertion failed");
`else
`define U8BMP_ASSERT_NOW(lbl, ante, cons)
`define U8BMP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/u8bmp_pkg.sv @@
// Package for the UTF-8 BMP decoder: constants and shared types.
// No dependencies.
package u8bmp_pkg;

  // Lead byte patterns and masks.
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_CODE  = 8'hE0;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_CODE  = 8'hC0;

  // Printable ASCII range.
  localparam logic [7:0] ASCII_LOW   = 8'h20;
  localparam logic [7:0] ASCII_HIGH  = 8'h7E;

  // Code point substitution: fullwidth tilde becomes wave dash.
  localparam logic [15:0] SUBST_FROM = 16'hFF5E;
  localparam logic [15:0] SUBST_TO   = 16'h301C;

  // Continuation bytes still expected.
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  // One result produced by the decode step.
  typedef struct packed {
    logic        valid;
    logic [15:0] code_point;
    logic        string_end;
  } step_res_t;

endpackage

@@ rtl/core/u8bmp_byte_if.sv @@
// Byte input channel of the UTF-8 BMP decoder.
// No dependencies.
interface u8bmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

@@ rtl/core/u8bmp_code_if.sv @@
// Code point output channel of the UTF-8 BMP decoder.
// No dependencies.
interface u8bmp_code_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_point;
  logic        string_end;

  modport source (output valid, output code_point, output string_end, input ready);
  modport sink (input valid, input code_point, input string_end, output ready);
endinterface

@@ rtl/core/u8bmp_step.sv @@
// Decode step of the UTF-8 BMP decoder: sequence state and per-byte logic.
// Depends on u8bmp_pkg.
module u8bmp_step
  import u8bmp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  output step_res_t  res_o
);

  logic [1:0]  pending_q, pending_d;
  logic [9:0]  partial_q, partial_d;
  logic [15:0] acc;

  // The accumulated code point once this byte's six payload bits are added.
  assign acc = {partial_q, byte_i[5:0]};

  // Next state and result for the byte presented at the input.
  always_comb begin
    pending_d        = pending_q;
    partial_d        = partial_q;
    res_o.valid      = 1'b0;
    res_o.code_point = '0;
    res_o.string_end = 1'b0;
    if (byte_i == 8'h00) begin
      // Terminator drops any partial sequence.
      pending_d        = PEND_NONE;
      partial_d        = '0;
      res_o.valid      = 1'b1;
      res_o.string_end = 1'b1;
    end else if (pending_q != PEND_NONE) begin
      pending_d = pending_q - 2'd1;
      if (pending_q == PEND_ONE) begin
        partial_d        = '0;
        res_o.valid      = 1'b1;
        res_o.code_point = (acc == SUBST_FROM) ? SUBST_TO : acc;
      end else begin
        partial_d = acc[9:0];
      end
    end else if ((byte_i & LEAD3_MASK) == LEAD3_CODE) begin
      pending_d = PEND_TWO;
      partial_d = {6'd0, byte_i[3:0]};
    end else if ((byte_i & LEAD2_MASK) == LEAD2_CODE) begin
      pending_d = PEND_ONE;
      partial_d = {5'd0, byte_i[4:0]};
    end else begin
      // Printable ASCII passes through; anything else reads as zero.
      res_o.valid = 1'b1;
      if (byte_i >= ASCII_LOW && byte_i <= ASCII_HIGH) begin
        res_o.code_point = {8'd0, byte_i};
      end
    end
  end

  // State advances only when a transaction is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= PEND_NONE;
      partial_q <= '0;
    end else if (fire_i) begin
      pending_q <= pending_d;
      partial_q <= partial_d;
    end
  end

endmodule

@@ rtl/core/u8bmp_out_reg.sv @@
// Result register of the UTF-8 BMP decoder with its handshake control.
// Depends on u8bmp_pkg and u8bmp_code_if.
module u8bmp_out_reg
  import u8bmp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  step_res_t           res_i,
  output logic                in_ready_o,
  u8bmp_code_if.source        out_o
);

  logic        valid_q;
  logic [15:0] code_q;
  logic        end_q;

  // A new transaction may enter when the register is empty or being drained.
  assign in_ready_o = !valid_q || out_o.ready;

  // Valid flag: set by a result, cleared when the result is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (fire_i && res_i.valid) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // Payload loads only with a new result.
  always_ff @(posedge clk_i) begin
    if (fire_i && res_i.valid) begin
      code_q <= res_i.code_point;
      end_q  <= res_i.string_end;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.code_point = code_q;
  assign out_o.string_end = end_q;

endmodule

@@ rtl/core/utf8_bmp_decoder.sv @@
// Top level of the UTF-8 BMP decoder.
// Depends on u8bmp_pkg, u8bmp_byte_if, u8bmp_code_if, u8bmp_step and u8bmp_out_reg.
//
//   Port    Dir  Content                        Per transaction
//   in_i    in   byte_in[7:0]                   one UTF-8 byte
//   out_o   out  code_point[15:0], string_end   zero or one decoded character
//
// One byte is accepted per cycle unless input is stalled; a result appears in
// the output register on the cycle after its final byte. Throughput is set by
// the single result register, which can be loaded and drained in the same cycle.
// Reset clears the sequence state and empties the output register.
// When a result is held and the sink is not ready, input is stalled.
`include "utf8_bmp_decoder_defines.svh"
module utf8_bmp_decoder
  import u8bmp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  u8bmp_byte_if.sink    in_i,
  u8bmp_code_if.source  out_o
);

  step_res_t step_res;
  logic      in_ready;
  logic      fire;

  assign in_i.ready = in_ready;
  assign fire       = in_i.valid && in_ready;

  // Per-byte decode and sequence state.
  u8bmp_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_i.byte_in),
    .res_o  (step_res)
  );

  // Result register.
  u8bmp_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .res_i      (step_res),
    .in_ready_o (in_ready),
    .out_o      (out_o)
  );

  // Input stalls only behind a result that is held back.
  `U8BMP_ASSERT_NOW(a_stall_cause, !in_i.ready, out_o.valid && !out_o.ready)
  // An accepted terminator gives a result with the end mark next cycle.
  `U8BMP_ASSERT_NEXT(a_term_result, fire && in_i.byte_in == '0, out_o.valid && out_o.string_end)
  // The end mark always travels with a zero code.
  `U8BMP_ASSERT_NOW(a_end_zero, out_o.valid && out_o.string_end, out_o.code_point == 16'h0000)

endmodule
